// ===== sv/mlfp_pkg.sv =====
// Shared types, codes and the brightness curve of the multichannel LED fade PWM.
`default_nettype none
package mlfp_pkg;

	localparam int unsigned IDX_W      = 6;
	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned PHASE_W    = 8;
	localparam int unsigned LED_W      = 8;
	localparam logic [IDX_W-1:0]   TABLE_LAST  = 6'd50;
	localparam logic [LEVEL_W-1:0] LEVEL_LIMIT = 8'd101;
	localparam logic [PHASE_W-1:0] PHASE_LAST  = 8'hFF;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [PHASE_W-1:0] phase_t;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_FADE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// Control shared by every channel for one transfer.
	typedef struct packed {
		logic   en;
		logic   step;
		logic   load;
		logic   jump;
		idx_t   target;
		phase_t phase_next;
	} chan_ctl_t;

	function automatic phase_t curve_at(input idx_t idx);
		phase_t v;
		case (idx)
			6'd0, 6'd1, 6'd2, 6'd3:                 v = 8'd0;
			6'd4, 6'd5, 6'd6, 6'd7, 6'd8:           v = 8'd1;
			6'd9, 6'd10, 6'd11:                     v = 8'd2;
			6'd12, 6'd13:                           v = 8'd3;
			6'd14, 6'd15:                           v = 8'd4;
			6'd16:                                  v = 8'd5;
			6'd17, 6'd18:                           v = 8'd6;
			6'd19:                                  v = 8'd7;
			6'd20:                                  v = 8'd8;
			6'd21:                                  v = 8'd9;
			6'd22:                                  v = 8'd10;
			6'd23:                                  v = 8'd12;
			6'd24:                                  v = 8'd13;
			6'd25:                                  v = 8'd15;
			6'd26:                                  v = 8'd17;
			6'd27:                                  v = 8'd19;
			6'd28:                                  v = 8'd21;
			6'd29:                                  v = 8'd24;
			6'd30:                                  v = 8'd27;
			6'd31:                                  v = 8'd30;
			6'd32:                                  v = 8'd34;
			6'd33:                                  v = 8'd38;
			6'd34:                                  v = 8'd42;
			6'd35:                                  v = 8'd47;
			6'd36:                                  v = 8'd53;
			6'd37:                                  v = 8'd59;
			6'd38:                                  v = 8'd66;
			6'd39:                                  v = 8'd74;
			6'd40:                                  v = 8'd83;
			6'd41:                                  v = 8'd93;
			6'd42:                                  v = 8'd104;
			6'd43:                                  v = 8'd116;
			6'd44:                                  v = 8'd130;
			6'd45:                                  v = 8'd145;
			6'd46:                                  v = 8'd162;
			6'd47:                                  v = 8'd181;
			6'd48:                                  v = 8'd203;
			6'd49:                                  v = 8'd226;
			default:                                v = 8'd253;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/mlfp_cmd_if.sv =====
// Command channel interface: valid, ready and the op, channel and level fields.
`default_nettype none
interface mlfp_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [2:0] channel;
	logic [7:0] level;

	modport source (output valid, output op, output channel, output level, input ready);
	modport sink (input valid, input op, input channel, input level, output ready);
endinterface
`default_nettype wire

// ===== sv/mlfp_res_if.sv =====
// Result channel interface: valid, ready and the LED and phase fields.
`default_nettype none
interface mlfp_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] led_outputs;
	logic [7:0] phase;

	modport source (output valid, output led_outputs, output phase, input ready);
	modport sink (input valid, input led_outputs, input phase, output ready);
endinterface
`default_nettype wire

// ===== sv/mlfp_channel.sv =====
// One channel: brightness index, fade direction and remaining steps, plus its LED decision.
`default_nettype none
module mlfp_channel (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mlfp_pkg::chan_ctl_t ctl,
	input  wire logic              sel,
	output logic                   lit_next
);
	import mlfp_pkg::*;

	idx_t idx_q;
	dir_t dir_q;
	idx_t steps_q;
	idx_t idx_d;
	dir_t dir_d;
	idx_t steps_d;

	always_comb begin
		idx_d   = idx_q;
		dir_d   = dir_q;
		steps_d = steps_q;
		if (ctl.step && steps_q != '0) begin
			case (dir_q)
				DIR_UP: begin
					if (idx_q < TABLE_LAST) idx_d = idx_q + 6'd1;
				end
				DIR_DOWN: begin
					if (idx_q != '0) idx_d = idx_q - 6'd1;
				end
				default: begin
				end
			endcase
			steps_d = steps_q - 6'd1;
		end
		if (ctl.load && sel) begin
			if (ctl.jump) begin
				idx_d   = ctl.target;
				dir_d   = DIR_NONE;
				steps_d = '0;
			end else if (idx_q < ctl.target) begin
				dir_d   = DIR_UP;
				steps_d = ctl.target - idx_q;
			end else if (idx_q > ctl.target) begin
				dir_d   = DIR_DOWN;
				steps_d = idx_q - ctl.target;
			end else begin
				dir_d   = DIR_NONE;
				steps_d = '0;
			end
		end
	end

	assign lit_next = (idx_d != '0) && (ctl.phase_next < curve_at(idx_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			dir_q   <= DIR_NONE;
			steps_q <= '0;
		end else if (ctl.en) begin
			idx_q   <= idx_d;
			dir_q   <= dir_d;
			steps_q <= steps_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/multichannel_led_fade_pwm_unit.sv =====
// Top level of the multichannel LED PWM with light-bulb curve and stepwise fading.
//
// Commands arrive on the cmd channel: a tick advances the 8-bit PWM phase, a set
// jumps one channel to a brightness and a fade moves it there one curve step per
// fade period. Each accepted command yields exactly one transfer on the res channel
// carrying the LED pattern and the phase after that command.
// The cfg port writes the fade speed, in PWM periods per fade step, and should only
// be written while no result is outstanding. A fade speed of zero makes fades jump.
// The result register is loaded at the edge that accepts the command. One command
// is accepted every cycle while the receiver keeps up; the channel registers and
// the result register are updated together in a single pass.
// When the receiver stalls, the result stays in the output register and a new
// command is accepted in the same cycle that the held result is taken.
// Reset clears every channel to dark with no fade pending, sets the phase to zero,
// the fade divider to one, the fade speed to zero and leaves no result valid.
`default_nettype none
module multichannel_led_fade_pwm_unit #(
	parameter int unsigned NUM_CHANNELS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mlfp_cmd_if.sink        cmd,
	mlfp_res_if.source      res,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);
	import mlfp_pkg::*;

	logic [7:0]            speed_q;
	phase_t                phase_q;
	logic [7:0]            divider_q;
	logic                  res_valid_q;
	logic [LED_W-1:0]      led_q;
	phase_t                res_phase_q;

	logic                  accept;
	logic                  is_tick;
	logic                  is_load;
	logic                  wrap;
	logic                  step_now;
	logic [LEVEL_W:0]      level_sum;
	chan_ctl_t             ctl;
	logic [NUM_CHANNELS-1:0] lit;
	logic [LED_W-1:0]      led_next;

	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign is_tick   = (cmd.op == OP_TICK);
	assign is_load   = (cmd.op == OP_SET || cmd.op == OP_FADE) && (cmd.level < LEVEL_LIMIT);
	assign wrap      = is_tick && (phase_q == PHASE_LAST);
	assign step_now  = (divider_q == speed_q);
	assign level_sum = {1'b0, cmd.level} + 9'd1;

	always_comb begin
		ctl.en         = accept;
		ctl.step       = wrap && step_now;
		ctl.load       = is_load;
		ctl.jump       = (cmd.op == OP_SET) || (speed_q == '0);
		ctl.target     = level_sum[IDX_W:1];
		ctl.phase_next = is_tick ? phase_q + 8'd1 : phase_q;
	end

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
		mlfp_channel u_chan (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sel      (32'(cmd.channel) == 32'(c)),
			.lit_next (lit[c])
		);
	end

	for (genvar b = 0; b < LED_W; b++) begin : g_led
		if (b < NUM_CHANNELS) begin : g_on
			assign led_next[b] = lit[b];
		end else begin : g_off
			assign led_next[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= '0;
			phase_q     <= '0;
			divider_q   <= 8'd1;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) speed_q <= cfg_wdata;
			if (accept) begin
				phase_q <= ctl.phase_next;
				if (wrap) divider_q <= step_now ? 8'd1 : divider_q + 8'd1;
			end
			if (accept) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			led_q       <= led_next;
			res_phase_q <= ctl.phase_next;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.led_outputs = led_q;
	assign res.phase       = res_phase_q;

endmodule
`default_nettype wire
